// ===== sv/gdbm_pkg.sv =====
// Shared types and constants of the gradient direction background model.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package gdbm_pkg;

   localparam int GRAD_W      = 11;
   localparam int POS_W       = 18;
   localparam int THR_W       = 11;
   localparam int CNT_W       = 8;
   localparam int CLS_W       = 3;
   localparam int CLASS_COUNT = 5;
   localparam int SQ_W        = 2 * GRAD_W;

   localparam int FRAME_PIXELS_DEFAULT = 262144;

   localparam int QUEUE_DEPTH = 2;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 11;

   localparam logic [CSR_INDEX_W-1:0] CSR_MAGNITUDE_THRESHOLD = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_COUNT_LIMIT         = 2'd1;

   localparam logic [THR_W-1:0] THRESHOLD_RESET = 11'd20;
   localparam logic [CNT_W-1:0] LIMIT_RESET     = 8'd50;

   localparam logic [CLS_W-1:0] CLS_NONE  = 3'd0;
   localparam logic [CLS_W-1:0] CLS_LEFT  = 3'd1;
   localparam logic [CLS_W-1:0] CLS_UP    = 3'd2;
   localparam logic [CLS_W-1:0] CLS_RIGHT = 3'd3;
   localparam logic [CLS_W-1:0] CLS_DOWN  = 3'd4;

   // One classified pixel word as it travels from the front to the back.
   typedef struct packed {
      logic [CLS_W-1:0] direction_class;
      logic [POS_W-1:0] pixel_position;
      logic             in_range;
   } gdbm_item_type;

   typedef logic [CLASS_COUNT-1:0][CNT_W-1:0] gdbm_counters_type;

endpackage

// ===== sv/gdbm_front.sv =====
// Front end: accepts gradient words, squares the gradients and the threshold,
// then classifies the direction and pushes the word into the queue. Uses gdbm_pkg.
`timescale 1ns / 1ps

module gdbm_front import gdbm_pkg::*; #(
   parameter int FRAME_PIXELS = FRAME_PIXELS_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    clearing,
   input  logic [THR_W-1:0]        magnitude_threshold,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic signed [GRAD_W-1:0] req_grad_x,
   input  logic signed [GRAD_W-1:0] req_grad_y,
   input  logic [POS_W-1:0]        req_pixel_position,
   output logic                    push_valid,
   output gdbm_item_type           push_item,
   input  logic                    queue_full
);

   typedef struct packed {
      logic gx_neg;
      logic gx_pos;
      logic gy_neg;
      logic gy_eq_gx;
      logic ay_le_ax;
      logic ay_lt_ax;
   } gdbm_flags_type;

   logic [GRAD_W-1:0] ax;
   logic [GRAD_W-1:0] ay;
   logic              req_accept;

   logic              f1_valid_ff, f1_valid_in;
   logic [SQ_W-1:0]   f1_ax2_ff, f1_ax2_in;
   logic [SQ_W-1:0]   f1_ay2_ff, f1_ay2_in;
   logic [SQ_W-1:0]   f1_thr2_ff, f1_thr2_in;
   gdbm_flags_type    f1_flags_ff, f1_flags_in;
   logic [POS_W-1:0]  f1_pos_ff, f1_pos_in;
   logic              f1_in_range_ff, f1_in_range_in;

   logic [SQ_W:0]     mag2;
   logic [CLS_W-1:0]  cls;

   // The magnitude of -1024 is 1024, which still fits the unsigned width.
   assign ax = req_grad_x[GRAD_W-1] ? (~req_grad_x + 1'b1) : req_grad_x;
   assign ay = req_grad_y[GRAD_W-1] ? (~req_grad_y + 1'b1) : req_grad_y;

   assign req_ready  = !clearing && (!f1_valid_ff || !queue_full);
   assign req_accept = req_valid && req_ready;
   assign push_valid = f1_valid_ff && !queue_full;

   always_comb begin
      f1_valid_in    = f1_valid_ff;
      f1_ax2_in      = f1_ax2_ff;
      f1_ay2_in      = f1_ay2_ff;
      f1_thr2_in     = f1_thr2_ff;
      f1_flags_in    = f1_flags_ff;
      f1_pos_in      = f1_pos_ff;
      f1_in_range_in = f1_in_range_ff;
      if (req_accept) begin
         f1_valid_in          = 1'b1;
         f1_ax2_in            = SQ_W'(ax) * SQ_W'(ax);
         f1_ay2_in            = SQ_W'(ay) * SQ_W'(ay);
         f1_thr2_in           = SQ_W'(magnitude_threshold) * SQ_W'(magnitude_threshold);
         f1_flags_in.gx_neg   = req_grad_x[GRAD_W-1];
         f1_flags_in.gx_pos   = !req_grad_x[GRAD_W-1] && (req_grad_x != '0);
         f1_flags_in.gy_neg   = req_grad_y[GRAD_W-1];
         f1_flags_in.gy_eq_gx = (req_grad_y == req_grad_x);
         f1_flags_in.ay_le_ax = (ay <= ax);
         f1_flags_in.ay_lt_ax = (ay < ax);
         f1_pos_in            = req_pixel_position;
         f1_in_range_in       = (32'(req_pixel_position) < 32'(FRAME_PIXELS));
      end else if (push_valid) begin
         f1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_valid_ff <= 1'b0;
      end else begin
         f1_valid_ff <= f1_valid_in;
      end
      f1_ax2_ff      <= f1_ax2_in;
      f1_ay2_ff      <= f1_ay2_in;
      f1_thr2_ff     <= f1_thr2_in;
      f1_flags_ff    <= f1_flags_in;
      f1_pos_ff      <= f1_pos_in;
      f1_in_range_ff <= f1_in_range_in;
   end

   assign mag2 = {1'b0, f1_ax2_ff} + {1'b0, f1_ay2_ff};

   // Diagonal ties fall out of the order of these tests.
   always_comb begin
      priority if (mag2 <= {1'b0, f1_thr2_ff}) begin
         cls = CLS_NONE;
      end else if (f1_flags_ff.gx_neg && f1_flags_ff.ay_le_ax) begin
         cls = CLS_LEFT;
      end else if (f1_flags_ff.gx_pos && (f1_flags_ff.ay_lt_ax || f1_flags_ff.gy_eq_gx)) begin
         cls = CLS_RIGHT;
      end else if (f1_flags_ff.gy_neg) begin
         cls = CLS_UP;
      end else begin
         cls = CLS_DOWN;
      end
   end

   assign push_item.direction_class = cls;
   assign push_item.pixel_position  = f1_pos_ff;
   assign push_item.in_range        = f1_in_range_ff;

endmodule

// ===== sv/gdbm_queue.sv =====
// Short queue of classified pixel words between the front and the back end.
// Uses gdbm_pkg for the word type and the depth.
`timescale 1ns / 1ps

module gdbm_queue import gdbm_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          push_valid,
   input  gdbm_item_type push_item,
   output logic          full,
   input  logic          pop,
   output logic          head_valid,
   output gdbm_item_type head_item
);

   localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CntW = $clog2(QUEUE_DEPTH + 1);

   gdbm_item_type       entry_ff [QUEUE_DEPTH];
   logic [PtrW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]     count_ff, count_in;
   logic                do_push;
   logic                do_pop;

   assign full       = (count_ff == CntW'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_item  = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ===== sv/gdbm_back.sv =====
// Back end: per-pixel counter memory with its clearing pass, read-modify-write
// with a bypass of the latest write, and the result register. Uses gdbm_pkg.
`timescale 1ns / 1ps

module gdbm_back import gdbm_pkg::*; #(
   parameter int FRAME_PIXELS = FRAME_PIXELS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic [CNT_W-1:0]  count_limit,
   output logic              clearing,
   input  logic              head_valid,
   input  gdbm_item_type     head_item,
   output logic              pop,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [CLS_W-1:0]  rsp_direction_class,
   output logic [CLS_W-1:0]  rsp_background_class
);

   localparam int MemDepth = (FRAME_PIXELS < (1 << POS_W)) ? FRAME_PIXELS : (1 << POS_W);
   localparam int AddrW    = (MemDepth > 1) ? $clog2(MemDepth) : 1;

   gdbm_counters_type  mem [MemDepth];
   gdbm_counters_type  mem_rdata_ff;

   logic               clr_active_ff, clr_active_in;
   logic [AddrW-1:0]   clr_addr_ff, clr_addr_in;

   logic               c_valid_ff, c_valid_in;
   gdbm_item_type      c_item_ff, c_item_in;
   logic               c_fire;
   logic [AddrW-1:0]   c_addr;
   logic [AddrW-1:0]   head_addr;

   logic               byp_valid_ff, byp_valid_in;
   logic [AddrW-1:0]   byp_addr_ff, byp_addr_in;
   gdbm_counters_type  byp_data_ff, byp_data_in;

   gdbm_counters_type  cur;
   gdbm_counters_type  nxt;
   logic [CNT_W-1:0]   best;
   logic [CLS_W-1:0]   best_idx;
   logic [CLS_W-1:0]   bg;
   logic               wr_en;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [CLS_W-1:0]   rsp_dir_ff, rsp_dir_in;
   logic [CLS_W-1:0]   rsp_bg_ff, rsp_bg_in;

   assign clearing  = clr_active_ff;
   assign c_addr    = c_item_ff.pixel_position[AddrW-1:0];
   assign head_addr = head_item.pixel_position[AddrW-1:0];
   assign c_fire    = c_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign pop       = head_valid && !clr_active_ff && (!c_valid_ff || c_fire);
   assign wr_en     = c_fire && c_item_ff.in_range;

   // The clearing pass zeroes one entry per cycle after reset.
   always_comb begin
      clr_active_in = clr_active_ff;
      clr_addr_in   = clr_addr_ff;
      if (clr_active_ff) begin
         clr_active_in = (clr_addr_ff != AddrW'(MemDepth - 1));
         clr_addr_in   = clr_addr_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (clr_active_ff) begin
         mem[clr_addr_ff] <= '0;
      end else if (wr_en) begin
         mem[c_addr] <= nxt;
      end
      if (pop) begin
         mem_rdata_ff <= mem[head_addr];
      end
   end

   // The latest write always matches the memory, so it can be forwarded at any time.
   assign cur = (byp_valid_ff && (byp_addr_ff == c_addr)) ? byp_data_ff : mem_rdata_ff;

   always_comb begin
      best     = '0;
      best_idx = CLS_NONE;
      for (int i = 0; i < CLASS_COUNT; i++) begin
         if (c_item_ff.direction_class == CLS_W'(i)) begin
            if (cur[i] <= count_limit) begin
               nxt[i] = (cur[i] == '1) ? cur[i] : cur[i] + 1'b1;
            end else begin
               nxt[i] = count_limit;
            end
         end else begin
            nxt[i] = (cur[i] != '0) ? cur[i] - 1'b1 : cur[i];
         end
         if (nxt[i] >= best) begin
            best     = nxt[i];
            best_idx = CLS_W'(i);
         end
      end
      bg = c_item_ff.in_range ? best_idx : CLS_NONE;
   end

   always_comb begin
      c_valid_in   = c_valid_ff;
      c_item_in    = c_item_ff;
      byp_valid_in = byp_valid_ff;
      byp_addr_in  = byp_addr_ff;
      byp_data_in  = byp_data_ff;
      rsp_dir_in   = rsp_dir_ff;
      rsp_bg_in    = rsp_bg_ff;
      if (pop) begin
         c_valid_in = 1'b1;
         c_item_in  = head_item;
      end else if (c_fire) begin
         c_valid_in = 1'b0;
      end
      if (wr_en) begin
         byp_valid_in = 1'b1;
         byp_addr_in  = c_addr;
         byp_data_in  = nxt;
      end
      if (c_fire) begin
         rsp_dir_in = c_item_ff.direction_class;
         rsp_bg_in  = bg;
      end
      rsp_valid_in = c_fire || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_active_ff <= 1'b1;
         clr_addr_ff   <= '0;
         c_valid_ff    <= 1'b0;
         byp_valid_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         clr_active_ff <= clr_active_in;
         clr_addr_ff   <= clr_addr_in;
         c_valid_ff    <= c_valid_in;
         byp_valid_ff  <= byp_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      c_item_ff   <= c_item_in;
      byp_addr_ff <= byp_addr_in;
      byp_data_ff <= byp_data_in;
      rsp_dir_ff  <= rsp_dir_in;
      rsp_bg_ff   <= rsp_bg_in;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_direction_class  = rsp_dir_ff;
   assign rsp_background_class = rsp_bg_ff;

   a_no_pop_while_clearing: assert property (@(posedge clock) disable iff (reset)
      clr_active_ff |-> !pop)
      else $error("word taken from the queue during the clearing pass");

   a_bypass_tracks_write: assert property (@(posedge clock) disable iff (reset)
      wr_en |=> byp_valid_ff && (byp_addr_ff == $past(c_addr)))
      else $error("bypass register does not hold the latest counter write");

   a_result_follows_fire: assert property (@(posedge clock) disable iff (reset)
      c_fire |=> rsp_valid_ff && (rsp_dir_ff == $past(c_item_ff.direction_class)))
      else $error("result register lost the word that completed");

endmodule

// ===== sv/gradient_direction_background_model_top.sv =====
// Top level of the gradient direction background model: configuration registers,
// front end, queue and back end. Uses gdbm_pkg, gdbm_front, gdbm_queue, gdbm_back.
`timescale 1ns / 1ps

// Usage
// The req channel takes one pixel word per clock while nothing stalls: the Sobel
// pair req_grad_x, req_grad_y and the linear address req_pixel_position. The rsp
// channel returns, in the same order, the direction class of that pixel and the
// background class taken from its five per-pixel counters after they are updated.
// Both channels use valid and ready. An accepted word passes these stages in
// order before it shows up on rsp_valid: one stage squares the gradients, one
// classifies and enters the queue, one reads the counter memory, and the update
// lands in the result register.
// Throughput is one word per clock when nothing stalls, set by the single counter
// memory doing one read and one write per cycle; a bypass of the latest write
// covers back to back words at the same pixel.
// After reset a clearing pass zeroes the counter memory, one pixel entry per
// cycle, over min(FRAME_PIXELS, 262144) entries; req_ready stays low meanwhile.
// Configuration writes on the csr port are taken at any time but are meant for
// an idle block. When the receiver holds rsp_ready low, the result waits in its
// register, the queue fills and then req_ready drops.

module gradient_direction_background_model_top import gdbm_pkg::*; #(
   parameter int FRAME_PIXELS = FRAME_PIXELS_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_write_enable,
   input  logic [CSR_INDEX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]    csr_data,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic signed [GRAD_W-1:0] req_grad_x,
   input  logic signed [GRAD_W-1:0] req_grad_y,
   input  logic [POS_W-1:0]         req_pixel_position,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [CLS_W-1:0]         rsp_direction_class,
   output logic [CLS_W-1:0]         rsp_background_class
);

   logic [THR_W-1:0]  threshold_ff, threshold_in;
   logic [CNT_W-1:0]  limit_ff, limit_in;
   logic              clearing;
   logic              push_valid;
   gdbm_item_type     push_item;
   logic              queue_full;
   logic              pop;
   logic              head_valid;
   gdbm_item_type     head_item;

   always_comb begin
      threshold_in = threshold_ff;
      limit_in     = limit_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_MAGNITUDE_THRESHOLD: threshold_in = csr_data[THR_W-1:0];
            CSR_COUNT_LIMIT:         limit_in     = csr_data[CNT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= THRESHOLD_RESET;
         limit_ff     <= LIMIT_RESET;
      end else begin
         threshold_ff <= threshold_in;
         limit_ff     <= limit_in;
      end
   end

   gdbm_front #(
      .FRAME_PIXELS(FRAME_PIXELS)
   ) u_front (
      .clock              (clock),
      .reset              (reset),
      .clearing           (clearing),
      .magnitude_threshold(threshold_ff),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_grad_x         (req_grad_x),
      .req_grad_y         (req_grad_y),
      .req_pixel_position (req_pixel_position),
      .push_valid         (push_valid),
      .push_item          (push_item),
      .queue_full         (queue_full)
   );

   gdbm_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push_valid(push_valid),
      .push_item (push_item),
      .full      (queue_full),
      .pop       (pop),
      .head_valid(head_valid),
      .head_item (head_item)
   );

   gdbm_back #(
      .FRAME_PIXELS(FRAME_PIXELS)
   ) u_back (
      .clock               (clock),
      .reset               (reset),
      .count_limit         (limit_ff),
      .clearing            (clearing),
      .head_valid          (head_valid),
      .head_item           (head_item),
      .pop                 (pop),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_direction_class (rsp_direction_class),
      .rsp_background_class(rsp_background_class)
   );

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench for gradient_direction_background_model_top.
// Holds its own predictor of the per-pixel direction counters and depends only on
// gdbm_pkg and the RTL of the block.
`timescale 1ns / 1ps

module testbench;
   import gdbm_pkg::*;

   localparam int PIXELS_IN_FRAME = FRAME_PIXELS_DEFAULT;
   localparam int GRAD_LIMIT      = 1020;
   localparam int IDLE_PERCENT    = 31;
   localparam int HOLD_CYCLES     = 120;
   localparam int DRAIN_CYCLES    = 8;
   localparam int MAX_REPORTS     = 10;
   localparam int POOL_SIZE       = 6;
   localparam int CYCLE_LIMIT     = 1500000;

   // The block decodes only two registers; these indexes must be ignored.
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_LOW  = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_HIGH = 2'd3;

   typedef struct packed {
      logic [CLS_W-1:0] direction_class;
      logic [CLS_W-1:0] background_class;
   } pixel_classes_type;

   class direction_tracker;
      int                threshold;
      int                limit;
      int                failures;
      gdbm_counters_type counter_store [int];
      pixel_classes_type expected_classes [$];

      function new();
         threshold = int'(THRESHOLD_RESET);
         limit     = int'(LIMIT_RESET);
         failures  = 0;
      endfunction

      function void report(string text);
         failures++;
         if (failures <= MAX_REPORTS) begin
            $display("%s", text);
         end
      endfunction

      function void set_register(logic [CSR_INDEX_W-1:0] index,
                                 logic [CSR_DATA_W-1:0] data);
         unique case (index)
            CSR_MAGNITUDE_THRESHOLD: begin
               threshold = int'(data[THR_W-1:0]);
            end
            CSR_COUNT_LIMIT: begin
               limit = int'(data[CNT_W-1:0]);
            end
            default: begin
            end
         endcase
      endfunction

      function logic [CLS_W-1:0] direction_of_gradient(int gx, int gy);
         int ax;
         int ay;
         ax = (gx < 0) ? -gx : gx;
         ay = (gy < 0) ? -gy : gy;
         if (ax * ax + ay * ay <= threshold * threshold) begin
            return CLS_NONE;
         end
         // Diagonal ties: both left diagonals go left, (a,a) right, (a,-a) up.
         if (gx < 0 && ay <= ax) begin
            return CLS_LEFT;
         end
         if (gx > 0 && (ay < ax || gy == gx)) begin
            return CLS_RIGHT;
         end
         if (gy < 0) begin
            return CLS_UP;
         end
         return CLS_DOWN;
      endfunction

      function void note_pixel(logic signed [GRAD_W-1:0] gx, logic signed [GRAD_W-1:0] gy,
                               logic [POS_W-1:0] pos);
         pixel_classes_type classes;
         gdbm_counters_type counts;
         int                value;
         int                best;
         int                i;
         classes.direction_class  = direction_of_gradient(int'(gx), int'(gy));
         classes.background_class = CLS_NONE;
         if (int'(pos) < PIXELS_IN_FRAME) begin
            counts = counter_store.exists(int'(pos)) ? counter_store[int'(pos)] : '0;
            best   = 0;
            for (i = 0; i < CLASS_COUNT; i++) begin
               value = int'(counts[i]);
               if (i == int'(classes.direction_class)) begin
                  // A counter above the limit (after the limit was lowered) drops to it.
                  if (value <= limit) begin
                     value = (value < 255) ? value + 1 : 255;
                  end else begin
                     value = limit;
                  end
               end else if (value > 0) begin
                  value = value - 1;
               end
               counts[i] = value[CNT_W-1:0];
               if (value >= best) begin
                  best = value;
                  classes.background_class = i[CLS_W-1:0];
               end
            end
            counter_store[int'(pos)] = counts;
         end
         expected_classes.push_back(classes);
      endfunction

      function void check_classes(logic [CLS_W-1:0] direction, logic [CLS_W-1:0] background);
         pixel_classes_type want;
         if (expected_classes.size() == 0) begin
            report($sformatf("unexpected word: direction %0d background %0d",
                             direction, background));
            return;
         end
         want = expected_classes.pop_front();
         if (want.direction_class !== direction) begin
            report($sformatf("direction_class mismatch: expected %0d, got %0d",
                             want.direction_class, direction));
         end
         if (want.background_class !== background) begin
            report($sformatf("background_class mismatch: expected %0d, got %0d",
                             want.background_class, background));
         end
      endfunction

      function int pending();
         return expected_classes.size();
      endfunction
   endclass

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     csr_write_enable = 1'b0;
   logic [CSR_INDEX_W-1:0]   csr_index = '0;
   logic [CSR_DATA_W-1:0]    csr_data = '0;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic signed [GRAD_W-1:0] req_grad_x = '0;
   logic signed [GRAD_W-1:0] req_grad_y = '0;
   logic [POS_W-1:0]         req_pixel_position = '0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic [CLS_W-1:0]         rsp_direction_class;
   logic [CLS_W-1:0]         rsp_background_class;

   direction_tracker tracker;
   int               pixel_pool [POOL_SIZE];
   logic             steady_stretch = 1'b0;
   int               hold_requests = 0;
   int               holds_served = 0;
   int               hold_left = 0;
   int               cycle_count = 0;

   gradient_direction_background_model_top uut (
      .clock                (clock),
      .reset                (reset),
      .csr_write_enable     (csr_write_enable),
      .csr_index            (csr_index),
      .csr_data             (csr_data),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_grad_x           (req_grad_x),
      .req_grad_y           (req_grad_y),
      .req_pixel_position   (req_pixel_position),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_direction_class  (rsp_direction_class),
      .rsp_background_class (rsp_background_class)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("TEST FAILED");
      $finish;
   end

   // Result side: check each accepted word, then choose the next ready level.
   always @(posedge clock) begin
      if (rsp_valid === 1'b1 && rsp_ready === 1'b1) begin
         tracker.check_classes(rsp_direction_class, rsp_background_class);
      end
      if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else if (holds_served != hold_requests) begin
         holds_served <= hold_requests;
         hold_left    <= HOLD_CYCLES;
         rsp_ready    <= 1'b0;
      end else begin
         rsp_ready <= steady_stretch || ($urandom_range(99) >= IDLE_PERCENT);
      end
   end

   function automatic int random_between(int lo, int hi);
      return lo + int'($urandom_range(hi - lo));
   endfunction

   // Builds a gradient pair that falls in the aimed direction when it is strong enough.
   function automatic void pick_gradient(input logic [CLS_W-1:0] aim,
                                         output int gx, output int gy);
      int a;
      a = ($urandom_range(3) == 0) ? random_between(1, 40) : random_between(1, GRAD_LIMIT);
      unique case (aim)
         CLS_LEFT: begin
            gx = -a;
            gy = ($urandom_range(7) == 0) ? (($urandom_range(1) == 0) ? a : -a)
                                          : random_between(-a, a);
         end
         CLS_RIGHT: begin
            gx = a;
            gy = ($urandom_range(7) == 0) ? a : random_between(1 - a, a - 1);
         end
         CLS_UP: begin
            gy = -a;
            gx = random_between(1 - a, a);
         end
         CLS_DOWN: begin
            gy = a;
            gx = random_between(1 - a, a - 1);
         end
         default: begin
            gx = random_between(-25, 25);
            gy = random_between(-25, 25);
         end
      endcase
   endfunction

   task automatic send_pixel(input int gx, input int gy, input int pos);
      req_valid          <= 1'b1;
      req_grad_x         <= gx[GRAD_W-1:0];
      req_grad_y         <= gy[GRAD_W-1:0];
      req_pixel_position <= pos[POS_W-1:0];
      do @(posedge clock); while (req_ready !== 1'b1);
      tracker.note_pixel(req_grad_x, req_grad_y, req_pixel_position);
      if (!steady_stretch && $urandom_range(99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < IDLE_PERCENT);
      end
   endtask

   // The sender stops offering words before it waits for the results to drain.
   task automatic wait_until_idle();
      req_valid <= 1'b0;
      while (tracker.pending() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_INDEX_W-1:0] index,
                                 input logic [CSR_DATA_W-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_data         <= data;
      @(posedge clock);
      tracker.set_register(index, data);
   endtask

   task automatic configure(input int threshold, input int limit);
      wait_until_idle();
      write_register(CSR_SPARE_LOW, CSR_DATA_W'($urandom_range(2047)));
      write_register(CSR_MAGNITUDE_THRESHOLD, CSR_DATA_W'(threshold));
      write_register(CSR_SPARE_HIGH, CSR_DATA_W'($urandom_range(2047)));
      // Bits above the counter width are don't-care for the limit register.
      write_register(CSR_COUNT_LIMIT, {3'($urandom_range(7)), 8'(limit)});
      csr_write_enable <= 1'b0;
   endtask

   task automatic random_run(input int pos, input logic [CLS_W-1:0] aim, input int length,
                             input int noise_percent);
      int gx;
      int gy;
      repeat (length) begin
         if (int'($urandom_range(99)) < noise_percent) begin
            gx = random_between(-GRAD_LIMIT, GRAD_LIMIT);
            gy = random_between(-GRAD_LIMIT, GRAD_LIMIT);
         end else begin
            pick_gradient(aim, gx, gy);
         end
         send_pixel(gx, gy, pos);
      end
   endtask

   // Runs of one direction at a few busy pixels build up the counters; the rest is noise.
   task automatic random_pixels(input int count);
      int               left;
      int               length;
      int               pos;
      logic [CLS_W-1:0] aim;
      left = count;
      while (left > 0) begin
         if ($urandom_range(99) < 85) begin
            pos    = pixel_pool[$urandom_range(POOL_SIZE - 1)];
            length = random_between(1, 24);
         end else begin
            pos    = int'($urandom_range(PIXELS_IN_FRAME - 1));
            length = 1;
         end
         aim = CLS_W'($urandom_range(int'(CLS_DOWN)));
         if (length > left) begin
            length = left;
         end
         random_run(pos, aim, length, 15);
         left -= length;
      end
   endtask

   initial begin
      tracker       = new();
      pixel_pool[0] = 0;
      pixel_pool[1] = PIXELS_IN_FRAME - 1;
      for (int i = 2; i < POOL_SIZE; i++) begin
         pixel_pool[i] = int'($urandom_range(PIXELS_IN_FRAME - 1));
      end
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed words at the reset settings; the first one also waits out the clearing pass.
      send_pixel(0, 0, 0);
      send_pixel(20, 0, 0);
      send_pixel(21, 0, 0);
      send_pixel(-21, 0, 0);
      send_pixel(0, -21, 0);
      send_pixel(0, 21, 0);
      send_pixel(12, 16, PIXELS_IN_FRAME - 1);
      send_pixel(12, 17, PIXELS_IN_FRAME - 1);
      send_pixel(12, -17, PIXELS_IN_FRAME - 1);
      send_pixel(-30, -30, pixel_pool[2]);
      send_pixel(-30, 30, pixel_pool[2]);
      send_pixel(30, 30, pixel_pool[2]);
      send_pixel(30, -30, pixel_pool[2]);
      send_pixel(GRAD_LIMIT, GRAD_LIMIT, pixel_pool[3]);
      send_pixel(-GRAD_LIMIT, -GRAD_LIMIT, pixel_pool[3]);
      send_pixel(GRAD_LIMIT, -GRAD_LIMIT, pixel_pool[3]);
      send_pixel(-GRAD_LIMIT, GRAD_LIMIT, pixel_pool[3]);
      send_pixel(GRAD_LIMIT, 0, PIXELS_IN_FRAME - 1);
      send_pixel(-GRAD_LIMIT, 0, PIXELS_IN_FRAME - 1);
      send_pixel(0, GRAD_LIMIT, 0);
      send_pixel(0, -GRAD_LIMIT, 0);
      send_pixel(1, -1, 0);

      // Zero threshold and a limit of 254: one long run drives a counter to saturation.
      configure(0, 254);
      random_run(pixel_pool[1], CLS_RIGHT, 280, 0);
      random_pixels(100);

      // Nothing can exceed the top threshold, so every word is class zero.
      configure(2047, 0);
      random_pixels(150);

      // A low limit under counters that are already far above it.
      configure(int'($urandom_range(60)), 10);
      steady_stretch <= 1'b1;
      random_pixels(200);
      steady_stretch <= 1'b0;

      configure(GRAD_LIMIT, int'($urandom_range(254)));
      random_pixels(200);

      configure(int'($urandom_range(2047)), int'($urandom_range(254)));
      hold_requests <= hold_requests + 1;
      random_pixels(150);

      configure(int'(THRESHOLD_RESET), int'(LIMIT_RESET));
      hold_requests <= hold_requests + 1;
      random_pixels(100);
      hold_requests <= hold_requests + 1;
      random_pixels(120);

      wait_until_idle();
      if (tracker.failures == 0 && tracker.pending() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
